/* rtl/sfrd_pkg.sv */
// Shared types, constants and codes for the serial frame deframer.
package sfrd_pkg;

	// Queue depths used as parameter defaults.
	localparam int TOK_DEPTH = 4;
	localparam int OUT_DEPTH = 2;

	// Configuration register indexes.
	localparam logic [0:0] REG_ADDRESS_INDEX = 1'b0;
	localparam logic [0:0] REG_MAX_LEN       = 1'b1;

	// Framing bytes.
	localparam logic [7:0] END_MARK = 8'hC1;
	localparam logic [7:0] ESC_MARK = 8'h7D;
	localparam logic [7:0] FLIP_BIT = 8'h20;

	// Expected receive address bytes, selected by the address index register.
	localparam logic [7:0] ADDR_TABLE [8] = '{
		8'h0e, 8'h20, 8'h42, 8'h64, 8'h86, 8'ha8, 8'hca, 8'hec
	};

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_OK   = 2'd1,
		KIND_CSUM = 2'd2,
		KIND_ADDR = 2'd3
	} kind_t;

	// Deframer phases.
	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_ADDR   = 3'd1,
		PH_BODY   = 3'd2,
		PH_ESCAPE = 3'd3,
		PH_DRAIN  = 3'd4
	} phase_t;

	// One classified received byte, passed from the front to the back.
	typedef struct packed {
		logic [7:0] data;
		logic       is_end;
		logic       is_esc;
		logic       addr_ok;
	} token_t;

	// One result transaction.
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		logic [7:0] byte_count;
		logic       last;
	} result_t;

endpackage

/* rtl/sfrd_front.sv */
// Front part: classifies received bytes and queues them as tokens.
module sfrd_front #(
	parameter int DEPTH = sfrd_pkg::TOK_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [7:0]          rx_byte,
	input  logic [2:0]          address_index,
	output logic                tok_valid,
	output sfrd_pkg::token_t    tok,
	input  logic                tok_take
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	sfrd_pkg::token_t mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	sfrd_pkg::token_t new_tok;
	logic             do_push;
	logic             do_pop;

	// Classify the incoming byte against the framing marks and the expected address.
	always_comb begin
		new_tok.data    = rx_byte;
		new_tok.is_end  = (rx_byte == sfrd_pkg::END_MARK);
		new_tok.is_esc  = (rx_byte == sfrd_pkg::ESC_MARK);
		new_tok.addr_ok = (rx_byte == sfrd_pkg::ADDR_TABLE[address_index]);
	end

	assign full      = (cnt_q == CW'(DEPTH));
	assign tok_valid = (cnt_q != '0);
	assign tok       = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = tok_valid && tok_take;

	// Token storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= new_tok;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/sfrd_back.sv */
// Back part: frame state machine and the result queue.
module sfrd_back #(
	parameter int DEPTH = sfrd_pkg::OUT_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tok_valid,
	input  sfrd_pkg::token_t    tok,
	output logic                tok_take,
	input  logic [7:0]          max_len,
	output logic                empty,
	input  logic                pop,
	output sfrd_pkg::result_t   res
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	sfrd_pkg::phase_t  phase_q;
	sfrd_pkg::phase_t  phase_d;
	logic [7:0]        sum_q;
	logic [7:0]        sum_d;
	logic [7:0]        count_q;
	logic [7:0]        count_d;
	logic [1:0]        drain_q;
	logic [1:0]        drain_d;
	logic              emit;
	sfrd_pkg::result_t new_res;

	sfrd_pkg::result_t mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     cnt_q;
	logic              out_pop;
	logic              out_push;

	// A token is taken whenever the result queue can absorb a result this cycle.
	assign out_pop  = pop && !empty;
	assign tok_take = tok_valid && ((cnt_q != CW'(DEPTH)) || out_pop);
	assign out_push = tok_take && emit;

	// Next phase and result for the token at the head of the token queue.
	always_comb begin
		phase_d            = phase_q;
		sum_d              = sum_q;
		count_d            = count_q;
		drain_d            = drain_q;
		emit               = 1'b0;
		new_res.kind       = sfrd_pkg::KIND_DATA;
		new_res.data_byte  = '0;
		new_res.byte_count = '0;
		new_res.last       = 1'b0;
		unique case (phase_q)
			sfrd_pkg::PH_IDLE: begin
				phase_d = sfrd_pkg::PH_ADDR;
			end
			sfrd_pkg::PH_ADDR: begin
				if (!tok.addr_ok) begin
					drain_d = 2'd3;
					phase_d = sfrd_pkg::PH_DRAIN;
				end else begin
					sum_d   = tok.data;
					count_d = '0;
					phase_d = sfrd_pkg::PH_BODY;
				end
			end
			sfrd_pkg::PH_DRAIN: begin
				drain_d = drain_q - 1'b1;
				if (drain_d == '0) begin
					phase_d      = sfrd_pkg::PH_IDLE;
					emit         = 1'b1;
					new_res.kind = sfrd_pkg::KIND_ADDR;
					new_res.last = 1'b1;
				end
			end
			sfrd_pkg::PH_BODY: begin
				if (tok.is_end) begin
					phase_d            = sfrd_pkg::PH_IDLE;
					emit               = 1'b1;
					new_res.kind       = (sum_q == '0) ? sfrd_pkg::KIND_OK
					                                   : sfrd_pkg::KIND_CSUM;
					new_res.byte_count = count_q;
					new_res.last       = 1'b1;
				end else begin
					sum_d = sum_q + tok.data;
					// Once the store is full, bytes are only summed.
					if (count_q < max_len) begin
						if (tok.is_esc) begin
							phase_d = sfrd_pkg::PH_ESCAPE;
						end else begin
							count_d            = count_q + 1'b1;
							emit               = 1'b1;
							new_res.data_byte  = tok.data;
							new_res.byte_count = count_d;
						end
					end
				end
			end
			sfrd_pkg::PH_ESCAPE: begin
				phase_d            = sfrd_pkg::PH_BODY;
				count_d            = count_q + 1'b1;
				emit               = 1'b1;
				new_res.data_byte  = tok.data ^ sfrd_pkg::FLIP_BIT;
				new_res.byte_count = count_d;
			end
			default: begin
				phase_d = sfrd_pkg::PH_IDLE;
			end
		endcase
	end

	// Frame state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sfrd_pkg::PH_IDLE;
			sum_q   <= '0;
			count_q <= '0;
			drain_q <= '0;
		end else if (tok_take) begin
			phase_q <= phase_d;
			sum_q   <= sum_d;
			count_q <= count_d;
			drain_q <= drain_d;
		end
	end

	// Result storage.
	always_ff @(posedge clk) begin
		if (out_push) begin
			mem_q[wr_ptr_q] <= new_res;
		end
	end

	assign empty = (cnt_q == '0);
	assign res   = mem_q[rd_ptr_q];

	// Result queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (out_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (out_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (out_push && !out_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!out_push && out_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/serial_frame_receive_deframer_unit.sv */
// Top level of the serial frame deframer: configuration registers and the two halves.
//
// The deframer accepts one received byte per clock cycle while full is low and returns
// at most one result per byte: each stored body byte after unescaping, a frame-ok or
// checksum error at the end marker, or an address abort after three bytes are drained
// following a wrong address byte. A byte enters a token queue (TOK_DEPTH entries)
// on the edge where push is high and full is low; the frame state machine consumes
// one token per cycle while the result queue has room or is being popped, and writes
// the token's result into the result queue (OUT_DEPTH entries), which shows it on the
// output ports. The result queue lets results wait while bytes keep arriving; full rises
// only when both queues are backed up.
// Configuration writes take effect at the next edge and should be made between frames.
module serial_frame_receive_deframer_unit #(
	parameter int TOK_DEPTH = sfrd_pkg::TOK_DEPTH,
	parameter int OUT_DEPTH = sfrd_pkg::OUT_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] rx_byte,
	output logic       empty,
	input  logic       pop,
	output logic [1:0] kind,
	output logic [7:0] data_byte,
	output logic [7:0] byte_count,
	output logic       last,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_data
);

	logic [2:0]        address_index_q;
	logic [7:0]        max_len_q;
	logic              tok_valid;
	sfrd_pkg::token_t  tok;
	logic              tok_take;
	sfrd_pkg::result_t res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			address_index_q <= '0;
			max_len_q       <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sfrd_pkg::REG_ADDRESS_INDEX: address_index_q <= cfg_data[2:0];
				sfrd_pkg::REG_MAX_LEN:       max_len_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	sfrd_front #(
		.DEPTH(TOK_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.rx_byte      (rx_byte),
		.address_index(address_index_q),
		.tok_valid    (tok_valid),
		.tok          (tok),
		.tok_take     (tok_take)
	);

	sfrd_back #(
		.DEPTH(OUT_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.tok_valid(tok_valid),
		.tok      (tok),
		.tok_take (tok_take),
		.max_len  (max_len_q),
		.empty    (empty),
		.pop      (pop),
		.res      (res)
	);

	// Result fields of the oldest waiting transaction.
	assign kind       = res.kind;
	assign data_byte  = res.data_byte;
	assign byte_count = res.byte_count;
	assign last       = res.last;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the serial frame deframer: directed frames, then random traffic.
module tb_top;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 175;
	localparam int PRINT_LIMIT   = 50;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] rx_byte;
	logic       empty;
	logic       pop;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic [7:0] byte_count;
	logic       last;
	logic       cfg_we;
	logic [0:0] cfg_index;
	logic [7:0] cfg_data;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int err_count   = 0;
	int bytes_sent  = 0;
	int cycle_count = 0;

	// Local copy of the deframer state and its two registers.
	sfrd_pkg::phase_t fr_phase;
	logic [7:0]       fr_sum;
	logic [7:0]       fr_count;
	logic [1:0]       fr_drain;
	logic [2:0]       addr_sel;
	logic [7:0]       store_limit;

	// Results the deframer still owes, oldest first.
	sfrd_pkg::result_t owed_results[$];

	serial_frame_receive_deframer_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.rx_byte    (rx_byte),
		.empty      (empty),
		.pop        (pop),
		.kind       (kind),
		.data_byte  (data_byte),
		.byte_count (byte_count),
		.last       (last),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// Free-running clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop if the run hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		if (err_count < PRINT_LIMIT)
			$display("[%0d] mismatch: %s", cycle_count, msg);
		err_count++;
	endtask

	function automatic sfrd_pkg::result_t make_result(input sfrd_pkg::kind_t k,
		input logic [7:0] d, input logic [7:0] c, input logic l);
		sfrd_pkg::result_t r;
		r.kind       = k;
		r.data_byte  = d;
		r.byte_count = c;
		r.last       = l;
		return r;
	endfunction

	// Advance the local deframer state by one received byte and queue any result.
	task automatic deframe_byte(input logic [7:0] b);
		case (fr_phase)
			sfrd_pkg::PH_IDLE: begin
				fr_phase = sfrd_pkg::PH_ADDR;
			end
			sfrd_pkg::PH_ADDR: begin
				if (b != sfrd_pkg::ADDR_TABLE[addr_sel]) begin
					fr_drain = 2'd3;
					fr_phase = sfrd_pkg::PH_DRAIN;
				end else begin
					fr_sum   = b;
					fr_count = 8'd0;
					fr_phase = sfrd_pkg::PH_BODY;
				end
			end
			sfrd_pkg::PH_DRAIN: begin
				fr_drain = fr_drain - 2'd1;
				if (fr_drain == 2'd0) begin
					fr_phase = sfrd_pkg::PH_IDLE;
					owed_results.push_back(make_result(sfrd_pkg::KIND_ADDR, 8'd0, 8'd0, 1'b1));
				end
			end
			sfrd_pkg::PH_BODY: begin
				if (b == sfrd_pkg::END_MARK) begin
					fr_phase = sfrd_pkg::PH_IDLE;
					owed_results.push_back(make_result(
						(fr_sum == 8'd0) ? sfrd_pkg::KIND_OK : sfrd_pkg::KIND_CSUM,
						8'd0, fr_count, 1'b1));
				end else begin
					fr_sum = fr_sum + b;
					if (fr_count < store_limit) begin
						if (b == sfrd_pkg::ESC_MARK) begin
							fr_phase = sfrd_pkg::PH_ESCAPE;
						end else begin
							fr_count = fr_count + 8'd1;
							owed_results.push_back(make_result(sfrd_pkg::KIND_DATA, b,
								fr_count, 1'b0));
						end
					end
				end
			end
			sfrd_pkg::PH_ESCAPE: begin
				fr_phase = sfrd_pkg::PH_BODY;
				fr_count = fr_count + 8'd1;
				owed_results.push_back(make_result(sfrd_pkg::KIND_DATA,
					b ^ sfrd_pkg::FLIP_BIT, fr_count, 1'b0));
			end
			default: begin
				fr_phase = sfrd_pkg::PH_IDLE;
			end
		endcase
	endtask

	// Receiver side: random stalls on pop.
	always @(posedge clk) begin
		if (arst_n)
			pop <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// Compare every popped result with the oldest owed one.
	always @(posedge clk) begin
		sfrd_pkg::result_t want;
		if (arst_n && pop && !empty) begin
			if (owed_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind %0d data %02h count %0d",
					kind, data_byte, byte_count));
			end else begin
				want = owed_results.pop_front();
				if (kind !== want.kind)
					report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
				if (data_byte !== want.data_byte)
					report_mismatch($sformatf("data_byte %02h, expected %02h",
						data_byte, want.data_byte));
				if (byte_count !== want.byte_count)
					report_mismatch($sformatf("byte_count %0d, expected %0d",
						byte_count, want.byte_count));
				if (last !== want.last)
					report_mismatch($sformatf("last %0b, expected %0b", last, want.last));
			end
		end
	end

	// Offer one byte, with random idle cycles first, and wait until it is taken.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push    <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (full);
		deframe_byte(b);
		bytes_sent++;
	endtask

	// Stop sending until every owed result has been popped.
	task automatic wait_drained();
		push <= 1'b0;
		do @(posedge clk); while (owed_results.size() != 0);
	endtask

	// Register write once the deframer has gone quiet.
	task automatic write_reg(input logic [0:0] idx, input logic [7:0] val);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == sfrd_pkg::REG_ADDRESS_INDEX)
			addr_sel = val[2:0];
		else
			store_limit = val;
	endtask

	// Feed end markers until the deframer is back waiting for a start byte.
	task automatic close_frame();
		while (fr_phase != sfrd_pkg::PH_IDLE)
			send_byte(sfrd_pkg::END_MARK);
	endtask

	function automatic logic [7:0] body_byte();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 12)
			return sfrd_pkg::ESC_MARK;
		if (pick < 16)
			return sfrd_pkg::END_MARK;
		if (pick < 18)
			return 8'h00;
		if (pick < 20)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	// One frame: start byte, address, body and an optional balancing checksum.
	task automatic send_frame(input bit good_addr, input bit good_sum, input int len);
		close_frame();
		send_byte(8'($urandom_range(0, 255)));
		send_byte(good_addr ? sfrd_pkg::ADDR_TABLE[addr_sel] : 8'($urandom_range(0, 255)));
		repeat (len) send_byte(body_byte());
		if (good_sum && fr_phase == sfrd_pkg::PH_BODY)
			send_byte(8'h00 - fr_sum);
		close_frame();
	endtask

	// New register settings between frames, extremes weighted in.
	task automatic random_config();
		int pick;
		logic [7:0] limit;
		pick = $urandom_range(0, 5);
		case (pick)
			0: limit = 8'd0;
			1: limit = 8'd255;
			2: limit = 8'($urandom_range(1, 3));
			3: limit = 8'($urandom_range(0, 255));
			default: limit = 8'($urandom_range(1, 10));
		endcase
		close_frame();
		write_reg(sfrd_pkg::REG_ADDRESS_INDEX, 8'($urandom_range(0, 7)));
		write_reg(sfrd_pkg::REG_MAX_LEN, limit);
	endtask

	// Extremes of the byte, every result kind, escapes, store full and zero length.
	task automatic test_directed_frames();
		write_reg(sfrd_pkg::REG_ADDRESS_INDEX, 8'd7);
		write_reg(sfrd_pkg::REG_MAX_LEN, 8'd255);
		// End marker as start byte, escaped end marker in the body, balanced sum.
		send_byte(sfrd_pkg::END_MARK);
		send_byte(sfrd_pkg::ADDR_TABLE[addr_sel]);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(sfrd_pkg::ESC_MARK);
		send_byte(sfrd_pkg::END_MARK);
		send_byte(8'h00 - fr_sum);
		send_byte(sfrd_pkg::END_MARK);

		// Nothing may be stored, and the sum is left unbalanced.
		write_reg(sfrd_pkg::REG_ADDRESS_INDEX, 8'd0);
		write_reg(sfrd_pkg::REG_MAX_LEN, 8'd0);
		send_byte(8'h00);
		send_byte(sfrd_pkg::ADDR_TABLE[addr_sel]);
		send_byte(sfrd_pkg::ESC_MARK);
		send_byte(8'h12);
		send_byte(sfrd_pkg::END_MARK);

		// Store fills after two bytes; a later escape is only summed.
		write_reg(sfrd_pkg::REG_MAX_LEN, 8'd2);
		send_byte(8'hFF);
		send_byte(sfrd_pkg::ADDR_TABLE[addr_sel]);
		send_byte(8'h11);
		send_byte(8'h22);
		send_byte(sfrd_pkg::ESC_MARK);
		send_byte(8'h33);
		send_byte(sfrd_pkg::END_MARK);

		// Wrong address: three bytes drained whatever they hold, then an abort.
		send_byte(8'h00);
		send_byte(sfrd_pkg::ADDR_TABLE[addr_sel] ^ 8'h01);
		send_byte(sfrd_pkg::ESC_MARK);
		send_byte(sfrd_pkg::END_MARK);
		send_byte(8'hFF);
	endtask

	// Mostly well-formed frames with random content, plus bad addresses and noise.
	task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_items);
		int start;
		int pick;
		int len;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		start = bytes_sent;
		random_config();
		while (bytes_sent - start < n_items) begin
			pick = $urandom_range(0, 99);
			len  = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 8);
			if (pick < 75)
				send_frame(1'b1, $urandom_range(0, 9) < 7, len);
			else if (pick < 88)
				send_frame(1'b0, 1'b0, len);
			else
				repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 29) == 0)
				wait_drained();
			if ($urandom_range(0, 11) == 0)
				random_config();
		end
	endtask

	// Test sequence.
	initial begin
		arst_n    <= 1'b0;
		push      <= 1'b0;
		rx_byte   <= 8'd0;
		pop       <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= sfrd_pkg::REG_ADDRESS_INDEX;
		cfg_data  <= 8'd0;
		fr_phase    = sfrd_pkg::PH_IDLE;
		fr_sum      = 8'd0;
		fr_count    = 8'd0;
		fr_drain    = 2'd0;
		addr_sel    = 3'd0;
		store_limit = 8'd0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 33;
		rx_idle_pct = 63;
		test_directed_frames();
		test_random_traffic(33, 63, RANDOM_ITEMS);
		test_random_traffic(63, 33, RANDOM_ITEMS);
		test_random_traffic(0, 0, RANDOM_ITEMS);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (owed_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", owed_results.size()));
		if (err_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
